[src/tlu_pkg.sv]
package tlu_pkg;

    // Number format: signed fixed point, Q8.24
    localparam int WORD_BITS = 32;
    localparam int FRAC_BITS = 24;
    localparam int PROD_BITS = 2 * WORD_BITS;

    localparam int BIAS_BITS     = 8;
    localparam int CFG_ADDR_BITS = 1;

    localparam int IN_DATA_BITS  = 3 * WORD_BITS;
    localparam int OUT_DATA_BITS = 4 * WORD_BITS;

    localparam logic signed [WORD_BITS-1:0] MAX_POS = {1'b0, {(WORD_BITS-1){1'b1}}};
    localparam logic signed [WORD_BITS-1:0] MIN_NEG = {1'b1, {(WORD_BITS-1){1'b0}}};
    localparam logic signed [WORD_BITS-1:0] FX_ONE  =
        {{(WORD_BITS-FRAC_BITS-1){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};

    localparam logic [BIAS_BITS-1:0] PIVOT_BIAS_RESET   = 8'd1;
    localparam logic [BIAS_BITS-1:0] INVERSE_BIAS_RESET = 8'd2;

    // Configuration register indexes
    localparam logic [CFG_ADDR_BITS-1:0] CFG_PIVOT_BIAS   = 1'd0;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_INVERSE_BIAS = 1'd1;

    typedef enum logic {
        SEL_UPPER   = 1'b0,
        SEL_INVERSE = 1'b1
    } t_div_sel;

    typedef struct packed {
        logic     load;
        logic     mul;
        logic     psat;
        logic     lsum;
        logic     div_start;
        t_div_sel div_sel;
        logic     u_load;
        logic     inv_load;
        logic     out_load;
    } t_cmd;

    typedef struct packed {
        logic last;
        logic div_done;
    } t_status;

    // Magnitude of a word; the most negative value maps to 2^(WORD_BITS-1)
    function automatic logic [WORD_BITS-1:0] f_mag(input logic signed [WORD_BITS-1:0] v);
        logic [WORD_BITS-1:0] neg_v;
        neg_v = WORD_BITS'(-v);
        return v[WORD_BITS-1] ? neg_v : WORD_BITS'(v);
    endfunction

    // Clamp a one-bit-wider sum into the word range
    function automatic logic signed [WORD_BITS-1:0] f_sat_word(
        input logic signed [WORD_BITS:0] v
    );
        logic signed [WORD_BITS-1:0] res;
        if (v[WORD_BITS] != v[WORD_BITS-1]) begin
            res = v[WORD_BITS] ? MIN_NEG : MAX_POS;
        end else begin
            res = v[WORD_BITS-1:0];
        end
        return res;
    endfunction

endpackage

[src/tridiagonal_lu_factor_top.sv]
// Tridiagonal LU factorization, one matrix row per input beat.
// No new row beat is taken until the current row's result is loaded for output.
// Each row runs up to two 31-step radix-2 divisions (one on a last row) in one
// shared divider; a zero divisor or oversized quotient ends a division early.
// Reset (i_rst_n low, synchronous): empties the block, pivot_bias = 1,
// inverse_bias = 2, and the kept upper factor of the previous row = 0.
module tridiagonal_lu_factor_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,

    // row beat
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // tdata, lowest bit up: sub_entry[31:0], diag_entry[63:32], super_entry[95:64]
    input  logic [tlu_pkg::IN_DATA_BITS-1:0]  i_s_axis_tdata,
    // tuser: first_row
    input  logic                              i_s_axis_tuser,
    // tlast: last_row
    input  logic                              i_s_axis_tlast,

    // result beat
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // tdata, lowest bit up: lower_c[31:0], pivot_l[63:32], upper_u[95:64],
    // pivot_inverse[127:96]
    output logic [tlu_pkg::OUT_DATA_BITS-1:0] o_m_axis_tdata,
    // tuser: divide_fault
    output logic                              o_m_axis_tuser,
    // tlast: row_done_last
    output logic                              o_m_axis_tlast,

    // configuration writes: index 0 pivot_bias, index 1 inverse_bias
    input  logic                              i_cfg_we,
    input  logic [tlu_pkg::CFG_ADDR_BITS-1:0] i_cfg_addr,
    input  logic [tlu_pkg::BIAS_BITS-1:0]     i_cfg_wdata
);
    import tlu_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;

    // The controller walks each row through multiply, product saturation,
    // pivot sum, then the upper-factor division (skipped on a last row) and
    // the reciprocal division. The result lands in an output register, so
    // the next row beat is taken while the previous result still waits.
    tlu_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (i_s_axis_tvalid),
        .o_s_ready (o_s_axis_tready),
        .o_m_valid (o_m_axis_tvalid),
        .i_m_ready (i_m_axis_tready),
        .i_status  (w_status),
        .o_cmd     (w_cmd)
    );

    // Datapath: row registers, 32x32 magnitude multiplier, saturating adds,
    // the shared divider, config registers and the kept upper factor.
    // The kept upper factor advances only when a result is loaded for output.
    tlu_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_data    (i_s_axis_tdata),
        .i_s_first   (i_s_axis_tuser),
        .i_s_last    (i_s_axis_tlast),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .o_m_data    (o_m_axis_tdata),
        .o_m_fault   (o_m_axis_tuser),
        .o_m_last    (o_m_axis_tlast)
    );

endmodule

[src/tlu_div.sv]
module tlu_div (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic signed [tlu_pkg::WORD_BITS-1:0] i_num,
    input  logic signed [tlu_pkg::WORD_BITS-1:0] i_den,
    output logic                                o_done,
    output logic signed [tlu_pkg::WORD_BITS-1:0] o_quo,
    output logic                                o_fault
);
    import tlu_pkg::*;

    localparam int SHIFT    = WORD_BITS - 1 - FRAC_BITS;
    localparam int ITERS    = WORD_BITS - 1;
    localparam int CNT_BITS = $clog2(ITERS);
    localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(ITERS - 1);

    typedef enum logic [3:0] {
        D_IDLE  = 4'b0001,
        D_SETUP = 4'b0010,
        D_ITER  = 4'b0100,
        D_FIN   = 4'b1000
    } t_div_state;

    t_div_state r_state, n_state;

    logic signed [WORD_BITS-1:0] r_num, r_den, r_sat_val;
    logic                        r_neg, r_sat, r_fault;
    logic [WORD_BITS-1:0]        r_d, r_rem;
    logic [WORD_BITS-2:0]        r_feed, r_q;
    logic [CNT_BITS-1:0]         r_cnt;

    logic [WORD_BITS-1:0] w_n, w_d, w_top;
    logic                 w_zero, w_ovf, w_ge;
    logic [WORD_BITS:0]   w_trial, w_diff;
    logic signed [WORD_BITS-1:0] w_q;

    assign w_n     = f_mag(r_num);
    assign w_d     = f_mag(r_den);
    assign w_top   = w_n >> SHIFT;
    assign w_zero  = (r_den == '0);
    // integer part too large when the top of the scaled numerator reaches the divisor
    assign w_ovf   = (w_top >= w_d);
    assign w_trial = {r_rem, r_feed[WORD_BITS-2]};
    assign w_ge    = (w_trial >= {1'b0, r_d});
    assign w_diff  = w_trial - {1'b0, r_d};
    assign w_q     = {1'b0, r_q};

    always_comb begin
        n_state = r_state;
        case (r_state)
            D_IDLE:  if (i_start) n_state = D_SETUP;
            D_SETUP: n_state = (w_zero || w_ovf) ? D_FIN : D_ITER;
            D_ITER:  if (r_cnt == CNT_LAST) n_state = D_FIN;
            D_FIN:   n_state = D_IDLE;
            default: n_state = D_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            D_IDLE: begin
                if (i_start) begin
                    r_num <= i_num;
                    r_den <= i_den;
                end
            end
            D_SETUP: begin
                r_neg   <= r_num[WORD_BITS-1] ^ r_den[WORD_BITS-1];
                r_d     <= w_d;
                r_rem   <= w_top;
                r_feed  <= {w_n[SHIFT-1:0], {FRAC_BITS{1'b0}}};
                r_cnt   <= '0;
                r_fault <= w_zero;
                r_sat   <= w_zero || w_ovf;
                if (w_zero) begin
                    r_sat_val <= r_num[WORD_BITS-1] ? MIN_NEG : MAX_POS;
                end else begin
                    r_sat_val <= (r_num[WORD_BITS-1] ^ r_den[WORD_BITS-1]) ? MIN_NEG : MAX_POS;
                end
            end
            D_ITER: begin
                r_rem  <= w_ge ? w_diff[WORD_BITS-1:0] : w_trial[WORD_BITS-1:0];
                r_q    <= {r_q[WORD_BITS-3:0], w_ge};
                r_feed <= r_feed << 1;
                r_cnt  <= r_cnt + 1'b1;
            end
            default: begin
            end
        endcase
    end

    assign o_done  = (r_state == D_FIN);
    assign o_quo   = r_sat ? r_sat_val : (r_neg ? -w_q : w_q);
    assign o_fault = r_fault;

endmodule

[src/tlu_dpath.sv]
module tlu_dpath (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic [tlu_pkg::IN_DATA_BITS-1:0]      i_s_data,
    input  logic                                  i_s_first,
    input  logic                                  i_s_last,
    input  logic                                  i_cfg_we,
    input  logic [tlu_pkg::CFG_ADDR_BITS-1:0]     i_cfg_addr,
    input  logic [tlu_pkg::BIAS_BITS-1:0]         i_cfg_wdata,
    input  tlu_pkg::t_cmd                         i_cmd,
    output tlu_pkg::t_status                      o_status,
    output logic [tlu_pkg::OUT_DATA_BITS-1:0]     o_m_data,
    output logic                                  o_m_fault,
    output logic                                  o_m_last
);
    import tlu_pkg::*;

    localparam int W = WORD_BITS;

    logic [BIAS_BITS-1:0] r_pivot_bias, r_inv_bias;
    logic signed [W-1:0]  r_prev;

    logic signed [W-1:0]  r_c, r_diag, r_sup, r_p, r_l, r_u, r_inv;
    logic                 r_last, r_pneg, r_fault;
    logic [PROD_BITS-1:0] r_prod;

    logic signed [W-1:0]  r_o_c, r_o_l, r_o_u, r_o_inv;
    logic                 r_o_fault, r_o_last;

    logic [W-1:0]              w_mc, w_mp;
    logic [PROD_BITS-1:0]      w_prod;
    logic [PROD_BITS-FRAC_BITS-1:0] w_m;
    logic                      w_m_ovf;
    logic signed [W-1:0]       w_m_low, w_p;
    logic signed [W:0]         w_diff, w_den_u_sum, w_den_i_sum;
    logic signed [W-1:0]       w_num, w_den;
    logic                      w_div_done, w_div_fault;
    logic signed [W-1:0]       w_quo;

    assign w_mc   = f_mag(r_c);
    assign w_mp   = f_mag(r_prev);
    assign w_prod = w_mc * w_mp;

    // truncate the product magnitude, then saturate by sign
    assign w_m     = r_prod[PROD_BITS-1:FRAC_BITS];
    assign w_m_ovf = |w_m[PROD_BITS-FRAC_BITS-1:W-1];
    assign w_m_low = {1'b0, w_m[W-2:0]};
    assign w_p     = w_m_ovf ? (r_pneg ? MIN_NEG : MAX_POS) : (r_pneg ? -w_m_low : w_m_low);

    assign w_diff      = {r_diag[W-1], r_diag} - {r_p[W-1], r_p};
    assign w_den_u_sum = {r_l[W-1], r_l} + {{(W+1-BIAS_BITS){1'b0}}, r_pivot_bias};
    assign w_den_i_sum = {r_l[W-1], r_l} + {{(W+1-BIAS_BITS){1'b0}}, r_inv_bias};

    assign w_num = (i_cmd.div_sel == SEL_UPPER) ? r_sup : FX_ONE;
    assign w_den = (i_cmd.div_sel == SEL_UPPER) ? f_sat_word(w_den_u_sum)
                                                : f_sat_word(w_den_i_sum);

    tlu_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (w_num),
        .i_den   (w_den),
        .o_done  (w_div_done),
        .o_quo   (w_quo),
        .o_fault (w_div_fault)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pivot_bias <= PIVOT_BIAS_RESET;
            r_inv_bias   <= INVERSE_BIAS_RESET;
            r_prev       <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_PIVOT_BIAS:   r_pivot_bias <= i_cfg_wdata;
                    CFG_INVERSE_BIAS: r_inv_bias   <= i_cfg_wdata;
                    default: begin
                    end
                endcase
            end
            if (i_cmd.out_load) begin
                r_prev <= r_u;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_c     <= i_s_first ? '0 : i_s_data[W-1:0];
            r_diag  <= i_s_data[2*W-1:W];
            r_sup   <= i_s_data[3*W-1:2*W];
            r_last  <= i_s_last;
            r_u     <= '0;
            r_fault <= 1'b0;
        end
        if (i_cmd.mul) begin
            r_prod <= w_prod;
            r_pneg <= r_c[W-1] ^ r_prev[W-1];
        end
        if (i_cmd.psat) begin
            r_p <= w_p;
        end
        if (i_cmd.lsum) begin
            r_l <= f_sat_word(w_diff);
        end
        if (i_cmd.u_load) begin
            r_u     <= w_quo;
            r_fault <= r_fault | w_div_fault;
        end
        if (i_cmd.inv_load) begin
            r_inv   <= w_quo;
            r_fault <= r_fault | w_div_fault;
        end
        if (i_cmd.out_load) begin
            r_o_c     <= r_c;
            r_o_l     <= r_l;
            r_o_u     <= r_u;
            r_o_inv   <= r_inv;
            r_o_fault <= r_fault;
            r_o_last  <= r_last;
        end
    end

    assign o_status.last     = r_last;
    assign o_status.div_done = w_div_done;

    assign o_m_data  = {r_o_inv, r_o_u, r_o_l, r_o_c};
    assign o_m_fault = r_o_fault;
    assign o_m_last  = r_o_last;

endmodule

[src/tlu_ctrl.sv]
module tlu_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_valid,
    output logic             o_s_ready,
    output logic             o_m_valid,
    input  logic             i_m_ready,
    input  tlu_pkg::t_status i_status,
    output tlu_pkg::t_cmd    o_cmd
);
    import tlu_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_MUL    = 9'b000000010,
        S_PSAT   = 9'b000000100,
        S_LSUM   = 9'b000001000,
        S_USTART = 9'b000010000,
        S_UWAIT  = 9'b000100000,
        S_ISTART = 9'b001000000,
        S_IWAIT  = 9'b010000000,
        S_OUT    = 9'b100000000
    } t_state;

    t_state r_state, n_state;
    logic   r_m_valid, n_m_valid;

    always_comb begin
        n_state         = r_state;
        o_cmd.load      = 1'b0;
        o_cmd.mul       = 1'b0;
        o_cmd.psat      = 1'b0;
        o_cmd.lsum      = 1'b0;
        o_cmd.div_start = 1'b0;
        o_cmd.div_sel   = SEL_UPPER;
        o_cmd.u_load    = 1'b0;
        o_cmd.inv_load  = 1'b0;
        o_cmd.out_load  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_s_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_PSAT;
            end
            S_PSAT: begin
                o_cmd.psat = 1'b1;
                n_state    = S_LSUM;
            end
            S_LSUM: begin
                o_cmd.lsum = 1'b1;
                n_state    = i_status.last ? S_ISTART : S_USTART;
            end
            S_USTART: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = SEL_UPPER;
                n_state         = S_UWAIT;
            end
            S_UWAIT: begin
                if (i_status.div_done) begin
                    o_cmd.u_load = 1'b1;
                    n_state      = S_ISTART;
                end
            end
            S_ISTART: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = SEL_INVERSE;
                n_state         = S_IWAIT;
            end
            S_IWAIT: begin
                if (i_status.div_done) begin
                    o_cmd.inv_load = 1'b1;
                    n_state        = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_m_valid || i_m_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        if (o_cmd.out_load) begin
            n_m_valid = 1'b1;
        end else if (i_m_ready) begin
            n_m_valid = 1'b0;
        end else begin
            n_m_valid = r_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_m_valid <= n_m_valid;
        end
    end

    assign o_s_ready = (r_state == S_IDLE);
    assign o_m_valid = r_m_valid;

endmodule

[src/tlu_check.sv]
module tlu_check (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_s_axis_tvalid,
    input logic                              o_s_axis_tready,
    input logic                              o_m_axis_tvalid,
    input logic                              i_m_axis_tready,
    input logic [tlu_pkg::OUT_DATA_BITS-1:0] o_m_axis_tdata,
    input logic                              o_m_axis_tuser,
    input logic                              o_m_axis_tlast
);
    import tlu_pkg::*;

    logic [WORD_BITS-1:0] w_upper, w_inv;

    assign w_upper = o_m_axis_tdata[3*WORD_BITS-1:2*WORD_BITS];
    assign w_inv   = o_m_axis_tdata[4*WORD_BITS-1:3*WORD_BITS];

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid)
        else $error("result beat dropped while stalled");

    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser) && $stable(o_m_axis_tlast))
        else $error("stalled result beat changed");

    a_one_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("second row taken while a row is in work");

    a_last_upper: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tlast |-> w_upper == '0)
        else $error("last row result carries a nonzero upper factor");

    a_fault_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser |->
            w_upper == MAX_POS || w_upper == MIN_NEG || w_inv == MAX_POS)
        else $error("divide fault without a saturated quotient");

endmodule

bind tridiagonal_lu_factor_top tlu_check u_tlu_check (.*);
